FILE: src/signed_number_to_seven_segment_assert.svh
// Assertion macros for the signed number to seven-segment block.
// Used by the port checker; depends on clk_i and rst_ni being in scope.
`ifndef SIGNED_NUMBER_TO_SEVEN_SEGMENT_ASSERT_SVH
`define SIGNED_NUMBER_TO_SEVEN_SEGMENT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SN7SEG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define SN7SEG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: src/sn7seg_pkg.sv
// Shared types, constants and the digit shape table for the seven-segment block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sn7seg_pkg;

  localparam int DigitCount  = 4;
  localparam int BcdW        = 4 * DigitCount;
  localparam int MagW        = 14;
  localparam int DabbleSteps = MagW / 2;
  localparam int StepW       = $clog2(DigitCount);

  localparam logic signed [15:0] ValueMax = 16'sd9999;
  localparam logic signed [15:0] ValueMin = -16'sd999;

  localparam logic [7:0] SegPoint = 8'h80;
  localparam logic [7:0] SegMinus = 8'h40;

  typedef struct packed {
    logic signed [15:0] value;
    logic [2:0]         point_position;
  } sn7seg_req_t;

  typedef struct packed {
    logic [2:0] digit_position;
    logic [7:0] segments;
    logic       last_write;
  } sn7seg_rsp_t;

  // Item as it moves through the conversion stages.
  typedef struct packed {
    logic [BcdW-1:0] bcd;
    logic [MagW-1:0] bin;
    logic            neg;
    logic [2:0]      point;
  } sn7seg_work_t;

  function automatic logic [7:0] digit_shape(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: src/sn7seg_range.sv
// Entry stage: range check and magnitude of the signed value.
// Depends on sn7seg_pkg.
`timescale 1ns / 1ps

module sn7seg_range import sn7seg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  sn7seg_req_t  req_i,
  output logic         valid_o,
  input  logic         ready_i,
  output sn7seg_work_t work_o
);

  logic         valid_q;
  logic         in_range;
  logic         neg;
  logic [15:0]  abs_val;
  sn7seg_work_t work_d, work_q;

  assign neg      = req_i.value < 16'sd0;
  assign in_range = (req_i.value <= ValueMax) && (req_i.value >= ValueMin);
  assign abs_val  = neg ? 16'(-req_i.value) : req_i.value;

  always_comb begin
    work_d       = '0;
    work_d.bin   = abs_val[MagW-1:0];
    work_d.neg   = neg;
    work_d.point = req_i.point_position;
  end

  assign ready_o = !valid_q || ready_i;

  // Requests outside the displayable range are taken and dropped here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i && in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

FILE: src/sn7seg_dabble.sv
// One shift-and-add-3 stage of the binary to BCD conversion.
// Depends on sn7seg_pkg.
`timescale 1ns / 1ps

module sn7seg_dabble import sn7seg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  sn7seg_work_t work_i,
  output logic         valid_o,
  input  logic         ready_i,
  output sn7seg_work_t work_o
);

  logic            valid_q;
  logic [BcdW-1:0] bcd;
  logic [MagW-1:0] bin;
  sn7seg_work_t    work_d, work_q;

  always_comb begin
    bcd = work_i.bcd;
    bin = work_i.bin;
    for (int s = 0; s < DabbleSteps; s++) begin
      for (int d = 0; d < DigitCount; d++) begin
        if (bcd[4*d +: 4] >= 4'd5) begin
          bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
        end
      end
      {bcd, bin} = {bcd, bin} << 1;
    end
    work_d     = work_i;
    work_d.bcd = bcd;
    work_d.bin = bin;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_d;
    end
  end

  assign valid_o = valid_q;
  assign work_o  = work_q;

endmodule

FILE: src/sn7seg_serial.sv
// Output stage: holds one converted value and sends its four digit writes.
// Depends on sn7seg_pkg.
`timescale 1ns / 1ps

module sn7seg_serial import sn7seg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  sn7seg_work_t work_i,
  output logic         valid_o,
  input  logic         ready_i,
  output sn7seg_rsp_t  rsp_o
);

  logic             valid_q;
  logic [StepW-1:0] step_q;
  sn7seg_work_t     work_q;
  logic             final_step;
  logic             minus_step;
  logic [StepW-1:0] idx;

  assign final_step = step_q == StepW'(DigitCount - 1);
  assign minus_step = work_q.neg && (step_q == '0);
  assign ready_o    = !valid_q || (ready_i && final_step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else if (ready_o) begin
      valid_q <= valid_i;
      step_q  <= '0;
    end else if (ready_i) begin
      step_q  <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      work_q <= work_i;
    end
  end

  // A negative value spends its first write on the minus sign.
  assign idx = step_q - StepW'(work_q.neg);

  always_comb begin
    rsp_o.last_write = final_step;
    if (minus_step) begin
      rsp_o.digit_position = 3'(DigitCount);
      rsp_o.segments       = SegMinus;
    end else begin
      rsp_o.digit_position = 3'(idx) + 3'd1;
      rsp_o.segments       = digit_shape(work_q.bcd[4*idx +: 4]);
      if (3'(idx) == work_q.point) begin
        rsp_o.segments = rsp_o.segments | SegPoint;
      end
    end
  end

  assign valid_o = valid_q;

endmodule

FILE: src/signed_number_to_seven_segment.sv
// Path: a taken request passes the range, conversion and output registers
// before its first digit write is offered. Throughput: one digit write per cycle
// while the receiver is ready; the output stage sends four writes per value from
// one register. Out-of-range values are taken at the input and give no writes.
// Reset: asynchronous, active low; clears all valid bits and the write counter.
`timescale 1ns / 1ps

module signed_number_to_seven_segment import sn7seg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sn7seg_req_t in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sn7seg_rsp_t out_rsp_o
);

  // The pipeline is four registered stages, each with its own valid bit:
  //   1. range check, sign and magnitude,
  //   2. first half of the shift-and-add-3 binary to BCD conversion,
  //   3. second half of that conversion,
  //   4. the output register, which walks through the four digit writes.
  // Each stage takes a new request whenever it is empty or its contents move
  // on in the same cycle, so a stall at the output backs up stage by stage
  // without losing or repeating anything.

  logic         rng_valid, rng_ready;
  sn7seg_work_t rng_work;
  logic         db0_valid, db0_ready;
  sn7seg_work_t db0_work;
  logic         db1_valid, db1_ready;
  sn7seg_work_t db1_work;

  sn7seg_range u_range (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (rng_valid),
    .ready_i (rng_ready),
    .work_o  (rng_work)
  );

  // The magnitude is below 10000, so fourteen shift steps finish the
  // conversion; each of the two stages does half of them.
  sn7seg_dabble u_dabble0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rng_valid),
    .ready_o (rng_ready),
    .work_i  (rng_work),
    .valid_o (db0_valid),
    .ready_i (db0_ready),
    .work_o  (db0_work)
  );

  sn7seg_dabble u_dabble1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (db0_valid),
    .ready_o (db0_ready),
    .work_i  (db0_work),
    .valid_o (db1_valid),
    .ready_i (db1_ready),
    .work_o  (db1_work)
  );

  // Positive values write positions 1 to 4 in order. Negative values write
  // the minus sign at position 4 first and then positions 1 to 3. The digit
  // whose index matches the point position gets the decimal point.
  sn7seg_serial u_serial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (db1_valid),
    .ready_o (db1_ready),
    .work_i  (db1_work),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule

FILE: src/sn7seg_checker.sv
// Port-level checks for the seven-segment block, bound to the top level.
// Depends on sn7seg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_number_to_seven_segment_assert.svh"

module sn7seg_checker import sn7seg_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input sn7seg_rsp_t out_rsp_o
);

  logic [2:0] pos;
  logic [7:0] seg;
  logic       last_wr;

  assign pos     = out_rsp_o.digit_position;
  assign seg     = out_rsp_o.segments;
  assign last_wr = out_rsp_o.last_write;

  `SN7SEG_ASSERT_NOW(pos_legal_a, out_valid_o, pos != 3'd0 && pos <= 3'd4)
  `SN7SEG_ASSERT_NOW(last_pos_a, out_valid_o && last_wr, pos == 3'd3 || pos == 3'd4)
  `SN7SEG_ASSERT_NOW(minus_only_a, out_valid_o && pos == 3'd4 && !last_wr, seg == SegMinus)
  `SN7SEG_ASSERT_NEXT(burst_a, out_valid_o && out_ready_i && !last_wr, out_valid_o)
  `SN7SEG_ASSERT_NEXT(hold_a, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

endmodule

bind signed_number_to_seven_segment sn7seg_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

FILE: verif/tb.sv
// Self-checking bench for signed_number_to_seven_segment: a predictor builds the
// digit writes each request should give and checks them in order. Uses sn7seg_pkg.
`timescale 1ns / 1ps

module tb;
  import sn7seg_pkg::*;

  localparam int ClkPeriod = 8;
  // Cycles with no transfer on either channel before the run is called hung.
  // The longest correct quiet stretch is the receiver hold-off below, so this
  // is many times the slowest legal wait.
  localparam int QuietLimit = 2000;
  localparam int HoldOffCycles = 64;
  localparam int RandomRequests = 294;
  // Cycles to keep watching after the last digit write, a few times the latency.
  localparam int TailCycles = 12;

  // Segment patterns for the digits 0..9, bit0 = a up to bit6 = g.
  localparam logic [7:0] DigitGlyph [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  sn7seg_req_t in_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  sn7seg_rsp_t out_rsp_o;

  signed_number_to_seven_segment dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Holds the digit writes still owed by the block, oldest first, and compares
  // every write the block hands over against the head of that list.
  class digit_write_board;
    sn7seg_rsp_t owed_writes[$];
    int unsigned errors;

    // Works out the writes one accepted request causes and queues them.
    function void note_request(sn7seg_req_t req);
      int          num;
      int unsigned mag;
      int unsigned count;
      sn7seg_rsp_t w;
      num = $signed(req.value);
      if (num >= 0 && num <= int'(ValueMax)) begin
        mag   = num;
        count = DigitCount;
      end else if (num < 0 && num >= int'(ValueMin)) begin
        // Negative values lead with a bare minus on the top digit, never pointed.
        w.digit_position = 3'(DigitCount);
        w.segments       = SegMinus;
        w.last_write     = 1'b0;
        owed_writes.push_back(w);
        mag   = -num;
        count = DigitCount - 1;
      end else begin
        return;
      end
      for (int unsigned i = 0; i < count; i++) begin
        w.digit_position = 3'(i + 1);
        w.segments       = DigitGlyph[mag % 10];
        if (i == req.point_position) w.segments = w.segments | SegPoint;
        w.last_write     = (i + 1 == count);
        mag              = mag / 10;
        owed_writes.push_back(w);
      end
    endfunction

    function void check_write(sn7seg_rsp_t got);
      sn7seg_rsp_t want;
      if (owed_writes.size() == 0) begin
        $display("%0t: unexpected digit write pos=%0d seg=%02h last=%0b",
                 $time, got.digit_position, got.segments, got.last_write);
        errors++;
        return;
      end
      want = owed_writes.pop_front();
      if (got.digit_position !== want.digit_position) begin
        $display("%0t: digit_position expected %0d got %0d",
                 $time, want.digit_position, got.digit_position);
        errors++;
      end
      if (got.segments !== want.segments) begin
        $display("%0t: segments at position %0d expected %02h got %02h",
                 $time, want.digit_position, want.segments, got.segments);
        errors++;
      end
      if (got.last_write !== want.last_write) begin
        $display("%0t: last_write at position %0d expected %0b got %0b",
                 $time, want.digit_position, want.last_write, got.last_write);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return owed_writes.size();
    endfunction
  endclass

  digit_write_board board;

  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int unsigned hold_off_asked;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the rising edge. Inputs only move at the
  // falling edge, so what is seen here is what the block saw.
  wire req_fire   = rst_ni && in_valid_i && in_ready_o;
  wire write_fire = rst_ni && out_valid_o && out_ready_i;

  always @(posedge clk_i) begin
    if (write_fire) board.check_write(out_rsp_o);
  end

  // Hang detector: counts cycles without any transfer.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || req_fire || write_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("signed_number_to_seven_segment: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. Its readiness follows a pattern that changes every so often:
  // always ready, mostly ready, a fixed one-in-three stall, and coin flips.
  // A long hold-off requested by the stimulus overrides the pattern.
  initial begin : write_sink
    int unsigned cyc;
    int unsigned hold_off_done;
    int unsigned hold_left;
    out_ready_i   = 1'b0;
    cyc           = 0;
    hold_off_done = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_off_asked != hold_off_done) begin
        hold_off_done = hold_off_asked;
        hold_left     = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          2:       out_ready_i <= (cyc % 3 != 0);
          default: out_ready_i <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  function automatic sn7seg_req_t make_request(int num, int point);
    sn7seg_req_t r;
    r.value          = 16'(num);
    r.point_position = 3'(point);
    return r;
  endfunction

  // Offers one request and holds it until the block takes it. Valid is not
  // dropped here, so back-to-back calls give an unbroken burst.
  task automatic offer_request(sn7seg_req_t req);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(req);
  endtask

  task automatic rest_sender(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Sender stays quiet until every owed write has come out.
  task automatic wait_for_drain();
    rest_sender(1);
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  // Random request, weighted toward displayable values so the digit path is
  // exercised most, with boundary values and arbitrary 16-bit noise mixed in.
  function automatic sn7seg_req_t random_request();
    int pick;
    int num;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      num = $urandom_range(0, 9999);
    end else if (pick < 80) begin
      num = -int'($urandom_range(1, 999));
    end else if (pick < 88) begin
      case ($urandom_range(0, 7))
        0:       num = 9998;
        1:       num = 9999;
        2:       num = 10000;
        3:       num = -998;
        4:       num = -999;
        5:       num = -1000;
        6:       num = 0;
        default: num = -1;
      endcase
    end else begin
      num = int'($signed(16'($urandom())));
    end
    return make_request(num, $urandom_range(0, 7));
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    hold_off_asked = 0;
    board          = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: field extremes, every digit shape, every point index,
    // a minus write with the point aimed at the minus slot, and values just
    // outside the displayable range that must give nothing.
    offer_request(make_request(0, 0));
    offer_request(make_request(9999, 3));
    offer_request(make_request(-999, 0));
    offer_request(make_request(-1, 1));
    offer_request(make_request(-1, 3));
    offer_request(make_request(10000, 0));
    offer_request(make_request(-1000, 2));
    offer_request(make_request(32767, 7));
    offer_request(make_request(-32768, 5));
    offer_request(make_request(1234, 4));
    offer_request(make_request(5678, 2));
    offer_request(make_request(-90, 2));
    offer_request(make_request(8, 1));
    offer_request(make_request(-7, 6));
    offer_request(make_request(4096, 3));
    offer_request(make_request(-512, 0));
    offer_request(make_request(7001, 1));
    wait_for_drain();

    // Random part, sent in bursts with random gaps; some gaps are zero so
    // long runs go by without any idle cycle.
    sent = 0;
    while (sent < RandomRequests) begin
      burst = $urandom_range(1, 12);
      if (sent >= 100 && hold_off_asked == 0) begin
        // Stall the receiver for a long stretch and keep offering requests,
        // so the pipeline fills and backs up onto the input.
        hold_off_asked++;
        burst = 24;
      end
      repeat (burst) begin
        offer_request(random_request());
        sent++;
      end
      if (sent >= 200 && sent < 200 + 12) wait_for_drain();
      else if ($urandom_range(0, 3) != 0) rest_sender($urandom_range(1, 8));
    end

    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("signed_number_to_seven_segment: match");
    end else begin
      $display("signed_number_to_seven_segment: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/sn7seg_pkg.sv
src/sn7seg_range.sv
src/sn7seg_dabble.sv
src/sn7seg_serial.sv
src/signed_number_to_seven_segment.sv
src/sn7seg_checker.sv
verif/tb.sv
